/* hdl/sv2c_pkg.sv */
package sv2c_pkg;

  localparam int DIMENSIONS   = 3;
  localparam int CORDIC_STEPS = 24;
  localparam int NSTEP = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0] GAIN_INV    = 34'sd652032874;
  localparam logic signed [31:0] HALF_RAD    = 32'sd32768;

  // floor(2^52 / (2*pi in Q.30)), i.e. floor(2^22 / 2*pi), for the angle quotient estimate
  localparam logic [19:0] TWO_PI_RECIP = 20'((64'sd1 <<< 52) / 64'(TWO_PI_Q30));

  localparam logic [2:0] REG_W_RAD = 3'd0;
  localparam logic [2:0] REG_W_POL = 3'd1;
  localparam logic [2:0] REG_W_AZI = 3'd2;
  localparam logic [2:0] REG_O_RAD = 3'd3;
  localparam logic [2:0] REG_O_POL = 3'd4;
  localparam logic [2:0] REG_O_AZI = 3'd5;

  function automatic logic signed [35:0] atan_q30(input int i);
    case (i)
      0: atan_q30 = 36'sd843314857;  1: atan_q30 = 36'sd497837829;
      2: atan_q30 = 36'sd263043837;  3: atan_q30 = 36'sd133525159;
      4: atan_q30 = 36'sd67021687;   5: atan_q30 = 36'sd33543516;
      6: atan_q30 = 36'sd16775851;   7: atan_q30 = 36'sd8388437;
      8: atan_q30 = 36'sd4194283;    9: atan_q30 = 36'sd2097149;
      default: atan_q30 = 36'sd1 <<< (30 - i);
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

/* hdl/spherical_vector_to_cartesian.sv */
// Spherical-to-Cartesian vector transform, Q16.16. One item enters per clock
// unless the output stalls, and passes through one coordinate stage, three
// angle-reduction stages, one stage per CORDIC iteration, three multiply
// stages and the output register. The whole pipeline advances together and
// stalls only when the output is held by out_tready low.
module spherical_vector_to_cartesian import sv2c_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // radial_index, polar_index, azimuth_index, comp_radial, comp_polar, comp_azimuth
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_slot_one, out_slot_two
  output logic [95:0]  out_tdata
);
  localparam int LAT = NSTEP + 8;

  logic [30:0] w_rad_r, w_pol_r, w_azi_r;
  logic signed [31:0] o_rad_r, o_pol_r, o_azi_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_rad_r <= 31'd65536; w_pol_r <= 31'd65536; w_azi_r <= 31'd65536;
      o_rad_r <= '0; o_pol_r <= '0; o_azi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_W_RAD: w_rad_r <= cfg_data[30:0];
        REG_W_POL: w_pol_r <= cfg_data[30:0];
        REG_W_AZI: w_azi_r <= cfg_data[30:0];
        REG_O_RAD: o_rad_r <= cfg_data;
        REG_O_POL: o_pol_r <= cfg_data;
        REG_O_AZI: o_azi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] v_r;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_tvalid};
  end
  assign out_tvalid = v_r[LAT-1];

  // stage 1: coordinates
  logic signed [31:0] r1_r, th1_r, ph1_r;
  logic signed [31:0] vr1_r, vt1_r, vp1_r;
  function automatic logic signed [31:0] coord(input logic signed [15:0] idx,
      input logic [30:0] w, input logic signed [31:0] o);
    logic signed [63:0] s;
    s = 64'(idx) * $signed({33'd0, w}) + $signed({34'd0, w[30:1]}) + 64'(o);
    coord = sat32(s);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r  <= coord(in_tdata[15:0], w_rad_r, o_rad_r);
      th1_r <= (DIMENSIONS > 1) ? coord(in_tdata[31:16], w_pol_r, o_pol_r) : HALF_RAD;
      ph1_r <= (DIMENSIONS > 2) ? coord(in_tdata[47:32], w_azi_r, o_azi_r) : '0;
      vr1_r <= in_tdata[79:48];
      vt1_r <= in_tdata[111:80];
      vp1_r <= in_tdata[143:112];
    end
  end

  logic signed [35:0] zt, zp;
  logic ft, fp;
  sv2c_angle u_at (.clk, .en, .ang(th1_r), .z_out(zt), .flip_out(ft));
  sv2c_angle u_ap (.clk, .en, .ang(ph1_r), .z_out(zp), .flip_out(fp));

  logic signed [33:0] st, ct, sp, cp;
  sv2c_cordic u_ct (.clk, .en, .z_in(zt), .flip_in(ft), .sin_out(st), .cos_out(ct));
  sv2c_cordic u_cp (.clk, .en, .z_in(zp), .flip_in(fp), .sin_out(sp), .cos_out(cp));

  // delay line for r and components to meet trig outputs
  localparam int DD = NSTEP + 3;
  logic signed [31:0] rd_r [DD], vrd_r [DD], vtd_r [DD], vpd_r [DD];
  always_ff @(posedge clk) begin
    if (en) begin
      rd_r[0] <= r1_r; vrd_r[0] <= vr1_r; vtd_r[0] <= vt1_r; vpd_r[0] <= vp1_r;
      for (int i = 1; i < DD; i++) begin
        rd_r[i] <= rd_r[i-1]; vrd_r[i] <= vrd_r[i-1];
        vtd_r[i] <= vtd_r[i-1]; vpd_r[i] <= vpd_r[i-1];
      end
    end
  end

  function automatic logic signed [63:0] rsh(input logic signed [95:0] v, input int s);
    logic signed [95:0] t;
    t = (v + (96'sd1 <<< (s - 1))) >>> s;
    rsh = t[63:0];
  endfunction

  // stage A: trig products
  logic signed [35:0] stcp_r, ctcp_r, stsp_r, ctsp_r, sta_r, cta_r;
  logic signed [31:0] ra_r, vra_r, vta_r, vpa_r;
  always_ff @(posedge clk) begin
    if (en) begin
      stcp_r <= 36'(rsh(96'(st) * 96'(cp), 30));
      ctcp_r <= 36'(rsh(96'(ct) * 96'(cp), 30));
      stsp_r <= 36'(rsh(96'(st) * 96'(sp), 30));
      ctsp_r <= 36'(rsh(96'(ct) * 96'(sp), 30));
      sta_r <= 36'(st); cta_r <= 36'(ct);
      ra_r <= rd_r[DD-1]; vra_r <= vrd_r[DD-1];
      vta_r <= vtd_r[DD-1]; vpa_r <= vpd_r[DD-1];
    end
  end

  // stage B: radius factors
  logic signed [36:0] rctcp_r, rstsp_r, rctsp_r, rstcp_r, rst_r;
  logic signed [35:0] stcpb_r, stspb_r, ctb_r;
  logic signed [31:0] vrb_r, vtb_r, vpb_r;
  always_ff @(posedge clk) begin
    if (en) begin
      rctcp_r <= 37'(rsh(96'(ra_r) * 96'(ctcp_r), 30));
      rstsp_r <= 37'(rsh(96'(ra_r) * 96'(stsp_r), 30));
      rctsp_r <= 37'(rsh(96'(ra_r) * 96'(ctsp_r), 30));
      rstcp_r <= 37'(rsh(96'(ra_r) * 96'(stcp_r), 30));
      rst_r   <= 37'(rsh(96'(ra_r) * 96'(sta_r), 30));
      stcpb_r <= stcp_r; stspb_r <= stsp_r; ctb_r <= cta_r;
      vrb_r <= vra_r; vtb_r <= vta_r; vpb_r <= vpa_r;
    end
  end

  // stage C: terms
  logic signed [63:0] xa_r, xb_r, xc_r, ya_r, yb_r, yc_r, za_r, zb_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xa_r <= rsh(96'(stcpb_r) * 96'(vrb_r), 30);
      xb_r <= rsh(96'(rctcp_r) * 96'(vtb_r), 16);
      xc_r <= rsh(96'(rstsp_r) * 96'(vpb_r), 16);
      ya_r <= rsh(96'(stspb_r) * 96'(vrb_r), 30);
      yb_r <= rsh(96'(rctsp_r) * 96'(vtb_r), 16);
      yc_r <= rsh(96'(rstcp_r) * 96'(vpb_r), 16);
      za_r <= rsh(96'(ctb_r) * 96'(vrb_r), 30);
      zb_r <= rsh(96'(rst_r) * 96'(vtb_r), 16);
    end
  end

  // stage D: sum and saturate into output register
  logic signed [31:0] ox, oy, oz;
  assign ox = sat32(xa_r + xb_r - xc_r);
  assign oy = sat32(ya_r + yb_r + yc_r);
  assign oz = sat32(za_r - zb_r);
  always_ff @(posedge clk) begin
    if (en) out_tdata <= (DIMENSIONS == 2) ? {oy, oz, ox} : {oz, oy, ox};
  end
endmodule

/* hdl/sv2c_cordic.sv */
// Pipelined rotation CORDIC, one register stage per iteration. Q.30.
module sv2c_cordic import sv2c_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic signed [35:0]  z_in,
  input  logic                flip_in,
  output logic signed [33:0]  sin_out,
  output logic signed [33:0]  cos_out
);
  logic signed [33:0] x_r [1:NSTEP];
  logic signed [33:0] y_r [1:NSTEP];
  logic signed [35:0] z_r [1:NSTEP];
  logic               f_r [1:NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_stage
    logic signed [33:0] xi, yi;
    logic signed [35:0] zi;
    logic               fi;

    // first stage starts from the gain-compensated unit vector
    if (i == 0) begin : g_in
      assign xi = GAIN_INV;
      assign yi = '0;
      assign zi = z_in;
      assign fi = flip_in;
    end else begin : g_link
      assign xi = x_r[i];
      assign yi = y_r[i];
      assign zi = z_r[i];
      assign fi = f_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[35]) begin
          x_r[i+1] <= xi - (yi >>> i);
          y_r[i+1] <= yi + (xi >>> i);
          z_r[i+1] <= zi - atan_q30(i);
        end else begin
          x_r[i+1] <= xi + (yi >>> i);
          y_r[i+1] <= yi - (xi >>> i);
          z_r[i+1] <= zi + atan_q30(i);
        end
        f_r[i+1] <= fi;
      end
    end
  end

  assign sin_out = y_r[NSTEP];
  assign cos_out = f_r[NSTEP] ? -x_r[NSTEP] : x_r[NSTEP];
endmodule

/* hdl/sv2c_angle.sv */
// Angle reduction to [-pi/2, pi/2] in Q.30, registered over three stages.
module sv2c_angle import sv2c_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ang,
  output logic signed [35:0] z_out,
  output logic               flip_out
);
  localparam logic [45:0] TWO_PI_W = 46'(TWO_PI_Q30[32:0]);

  logic [31:0]        mag;
  logic [45:0]        qprod;
  logic [31:0]        mag1_r;
  logic [12:0]        q1_r;
  logic               neg1_r;
  logic [45:0]        wide, qt, diff;
  logic [34:0]        rm;
  logic signed [35:0] rem;
  logic signed [35:0] z1_r;
  logic signed [35:0] z2, z3;
  logic               fl;

  // stage 1: |ang| and a quotient estimate by reciprocal multiply,
  // low by at most one
  always_comb begin
    mag   = ang[31] ? 32'(-(33'(ang))) : 32'(ang);
    qprod = 46'(mag[31:6]) * 46'(TWO_PI_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= mag;
      q1_r   <= qprod[44:32];
      neg1_r <= ang[31];
    end
  end

  // stage 2: remainder of |ang|*2^14 by 2*pi, one correction, dividend sign
  always_comb begin
    wide = {mag1_r, 14'd0};
    qt   = 46'(q1_r) * TWO_PI_W;
    diff = wide - qt;
    rm   = (diff >= TWO_PI_W) ? 35'(diff - TWO_PI_W) : diff[34:0];
    rem  = neg1_r ? -36'(rm) : 36'(rm);
  end

  always_ff @(posedge clk) if (en) z1_r <= rem;

  // stage 3: wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    z2 = z1_r;
    if (z2 > PI_Q30) z2 = z2 - TWO_PI_Q30;
    if (z2 < -PI_Q30) z2 = z2 + TWO_PI_Q30;
    fl = 1'b0;
    z3 = z2;
    if (z2 > HALF_PI_Q30) begin
      z3 = PI_Q30 - z2; fl = 1'b1;
    end else if (z2 < -HALF_PI_Q30) begin
      z3 = -PI_Q30 - z2; fl = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_out    <= z3;
      flip_out <= fl;
    end
  end
endmodule

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sv2c_pkg::*;

  typedef struct packed {
    logic signed [31:0] comp_azimuth;
    logic signed [31:0] comp_polar;
    logic signed [31:0] comp_radial;
    logic signed [15:0] azimuth_index;
    logic signed [15:0] polar_index;
    logic signed [15:0] radial_index;
  } cell_item_t;

  typedef struct packed {
    logic signed [31:0] slot_two;
    logic signed [31:0] slot_one;
    logic signed [31:0] x;
  } cart_vec_t;

  localparam int LATENCY = NSTEP + 12;
  localparam int WATCHDOG = 4000;
  localparam logic [2:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_W_RAD;
  logic [31:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;

  // shadow copy of the grid registers
  logic [30:0] w_rad = 31'd65536, w_pol = 31'd65536, w_azi = 31'd65536;
  logic signed [31:0] o_rad = '0, o_pol = '0, o_azi = '0;

  cell_item_t pending_items[$];
  cart_vec_t expected_vecs[$];
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int send_gap = 0;
  int sink_gap = 0;

  spherical_vector_to_cartesian u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint center_coord(longint idx, logic [30:0] w,
                                          logic signed [31:0] org);
    longint lw;
    lw = longint'({1'b0, w});
    return clamp32(idx * lw + (lw >>> 1) + longint'(org));
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[10];
    tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tab[i];
    return longint'(1) <<< (30 - i);
  endfunction

  // CORDIC rotation in Q.30 with quadrant fold
  task automatic trig(input longint ang, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = (ang * 16384) % 64'sd6746518852;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    if (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z = 64'sd3373259426 - z;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z = -64'sd3373259426 - z;
      flip = 1;
    end
    for (int i = 0; i < NSTEP; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    sn = y;
    cs = flip ? -x : x;
  endtask

  task automatic transform_cell(input cell_item_t it, output cart_vec_t res);
    longint r, th, ph, st, ct, sp, cp, stcp, ctcp, stsp, ctsp;
    longint ox, oy, oz, vr, vt, vp;
    r = center_coord(it.radial_index, w_rad, o_rad);
    th = (DIMENSIONS > 1) ? center_coord(it.polar_index, w_pol, o_pol) : 32768;
    ph = (DIMENSIONS > 2) ? center_coord(it.azimuth_index, w_azi, o_azi) : 0;
    vr = it.comp_radial; vt = it.comp_polar; vp = it.comp_azimuth;
    trig(th, st, ct);
    trig(ph, sp, cp);
    stcp = rnd_sh(st * cp, 30);
    ctcp = rnd_sh(ct * cp, 30);
    stsp = rnd_sh(st * sp, 30);
    ctsp = rnd_sh(ct * sp, 30);
    ox = clamp32(rnd_sh(stcp * vr, 30) + rnd_sh(rnd_sh(r * ctcp, 30) * vt, 16)
                 - rnd_sh(rnd_sh(r * stsp, 30) * vp, 16));
    oy = clamp32(rnd_sh(stsp * vr, 30) + rnd_sh(rnd_sh(r * ctsp, 30) * vt, 16)
                 + rnd_sh(rnd_sh(r * stcp, 30) * vp, 16));
    oz = clamp32(rnd_sh(ct * vr, 30) - rnd_sh(rnd_sh(r * st, 30) * vt, 16));
    res.x = ox[31:0];
    if (DIMENSIONS == 2) begin
      res.slot_one = oz[31:0]; res.slot_two = oy[31:0];
    end else begin
      res.slot_one = oy[31:0]; res.slot_two = oz[31:0];
    end
  endtask

  // register write with the shadow copy kept in step
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      REG_W_RAD: w_rad = val[30:0];
      REG_W_POL: w_pol = val[30:0];
      REG_W_AZI: w_azi = val[30:0];
      REG_O_RAD: o_rad = val;
      REG_O_POL: o_pol = val;
      REG_O_AZI: o_azi = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // checked between edges so every handshake of the edge is already counted
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || expected_vecs.size() != 0 || in_tvalid);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic cell_item_t rand_cell(bit wide);
    cell_item_t c;
    c.radial_index = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 64)) - 8);
    c.polar_index = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 64)) - 8);
    c.azimuth_index = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 128)) - 16);
    c.comp_radial = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 12);
    c.comp_polar = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 12);
    c.comp_azimuth = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 12);
    return c;
  endfunction

  // sender: one item per handshake, random bursts of idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        void'(pending_items.pop_front());
        n_items++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (!(in_tvalid && !in_tready) && !calm && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 9);
        in_tvalid <= 1'b0;
      end else if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (pending_items.size() > ((in_tvalid && in_tready) ? 0 : 0)) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_items[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // expectations are formed at acceptance, using the live register shadow
  always @(posedge clk) begin
    cart_vec_t e;
    if (rst_n && in_tvalid && in_tready) begin
      transform_cell(cell_item_t'(in_tdata), e);
      expected_vecs.push_back(e);
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    cart_vec_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        idle_cycles = 0;
        n_results++;
        if (expected_vecs.size() == 0) begin
          errors++;
          $display("%0t: unexpected item %h", $time, got);
        end else begin
          want = expected_vecs.pop_front();
          if (got.x !== want.x) begin
            errors++;
            $display("%0t: out_x exp %0d got %0d", $time, want.x, got.x);
          end
          if (got.slot_one !== want.slot_one) begin
            errors++;
            $display("%0t: out_slot_one exp %0d got %0d", $time, want.slot_one,
                     got.slot_one);
          end
          if (got.slot_two !== want.slot_two) begin
            errors++;
            $display("%0t: out_slot_two exp %0d got %0d", $time, want.slot_two,
                     got.slot_two);
          end
        end
      end else if (in_tvalid && in_tready) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        sink_gap = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no traffic for %0d cycles", WATCHDOG);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    cell_item_t c;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset grid, index and component extremes
    c = '0; pending_items.push_back(c);
    c.radial_index = 16'sh7FFF; c.polar_index = 16'sh7FFF; c.azimuth_index = 16'sh7FFF;
    c.comp_radial = 32'sh7FFFFFFF; c.comp_polar = 32'sh7FFFFFFF;
    c.comp_azimuth = 32'sh7FFFFFFF;
    pending_items.push_back(c);
    c.radial_index = 16'sh8000; c.polar_index = 16'sh8000; c.azimuth_index = 16'sh8000;
    c.comp_radial = 32'sh80000000; c.comp_polar = 32'sh80000000;
    c.comp_azimuth = 32'sh80000000;
    pending_items.push_back(c);
    c = '0; c.radial_index = 3; c.polar_index = 1; c.azimuth_index = 2;
    c.comp_radial = 32'sh10000; c.comp_polar = 32'sh10000; c.comp_azimuth = 32'sh10000;
    pending_items.push_back(c);
    c.radial_index = -1; c.polar_index = -2; c.azimuth_index = -4;
    pending_items.push_back(c);
    c.comp_radial = -32'sh10000; c.comp_polar = 32'sh7FFFFFFF;
    c.comp_azimuth = 32'sh80000000;
    pending_items.push_back(c);
    for (int k = 0; k < 6; k++) pending_items.push_back(rand_cell(1));
    drain();

    // several grid settings, extremes among them
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_W_RAD, 32'h7FFFFFFF); write_reg(REG_W_POL, 32'h7FFFFFFF);
          write_reg(REG_W_AZI, 32'h7FFFFFFF); write_reg(REG_O_RAD, 32'h7FFFFFFF);
          write_reg(REG_O_POL, 32'h7FFFFFFF); write_reg(REG_O_AZI, 32'h7FFFFFFF);
        end
        1: begin
          write_reg(REG_W_RAD, 0); write_reg(REG_W_POL, 0); write_reg(REG_W_AZI, 0);
          write_reg(REG_O_RAD, 32'h80000000); write_reg(REG_O_POL, 32'h80000000);
          write_reg(REG_O_AZI, 32'h80000000);
        end
        6: begin
          write_reg(REG_W_RAD, 32'h10000); write_reg(REG_W_POL, 32'h10000);
          write_reg(REG_W_AZI, 32'h10000); write_reg(REG_O_RAD, 0);
          write_reg(REG_O_POL, 0); write_reg(REG_O_AZI, 0);
          write_reg(REG_NONE, $urandom);
          calm = 1'b1;
        end
        default: begin
          write_reg(REG_W_RAD, $urandom_range(1, 32'h40000));
          write_reg(REG_W_POL, $urandom_range(1, 32'h8000));
          write_reg(REG_W_AZI, $urandom_range(1, 32'h10000));
          write_reg(REG_O_RAD, $urandom_range(0, 32'h100000));
          write_reg(REG_O_POL, $signed($urandom) >>> 10);
          write_reg(REG_O_AZI, $signed($urandom) >>> 8);
        end
      endcase
      for (int k = 0; k < 250; k++) begin
        pending_items.push_back(rand_cell($urandom_range(0, 9) == 0));
        // queueing of new items holds off until the pipe is empty
        if (k == 120) wait (pending_items.size() == 0 && expected_vecs.size() == 0);
      end
      drain();
    end

    $display("covered %0d cells over 8 grid settings with extreme widths and origins",
             n_items);
    $display("checked %0d transformed vectors", n_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
